>>> src/ncrs_pkg.sv
// Package: widths, register indexes, status codes and commands for the cubic root solver.
package ncrs_pkg;
  localparam int FracBits  = 24;
  localparam int DataWidth = 32;
  localparam int DW        = DataWidth;
  localparam int TolWidth  = 25;
  localparam int LimWidth  = 8;
  localparam int DivCntW   = 6;

  localparam logic [0:0] REG_TOLERANCE = 1'b0;
  localparam logic [0:0] REG_ITER_LIM  = 1'b1;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_NOT_CONV  = 2'd1;
  localparam logic [1:0] ST_ZERO_DER  = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  localparam logic [2:0] OP_IDLE  = 3'd0;
  localparam logic [2:0] OP_LOAD  = 3'd1;
  localparam logic [2:0] OP_SQ    = 3'd2;
  localparam logic [2:0] OP_CUBE  = 3'd3;
  localparam logic [2:0] OP_FUNC  = 3'd4;
  localparam logic [2:0] OP_TEST  = 3'd5;
  localparam logic [2:0] OP_DIVGO = 3'd6;
  localparam logic [2:0] OP_UPD   = 3'd7;

  typedef struct packed {
    logic [2:0] op;
  } ncrs_cmd_t;

  typedef struct packed {
    logic conv_ok;
    logic d_zero;
    logic div_done;
    logic step_small;
  } ncrs_sts_t;
endpackage

>>> src/ncrs_if.sv
// Valid/ready channel interface carrying a generic payload.
interface ncrs_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/ncrs_div.sv
// Restoring divider: saturated Q-format quotient n*2^F/d, one bit per cycle.
module ncrs_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic signed [ncrs_pkg::DW-1:0] num,
  input  logic signed [ncrs_pkg::DW-1:0] den,
  output logic                       done,
  output logic signed [ncrs_pkg::DW-1:0] quo
);
  import ncrs_pkg::*;
  localparam int QW = DW + FracBits;
  localparam int CntMax = QW;
  logic [QW-1:0]  n_r;
  logic [DW:0]    d_r;
  logic [DW:0]    rem_r;
  logic [QW-1:0]  q_r;
  logic           neg_r, busy_r, done_r;
  logic [DivCntW:0] cnt_r;
  logic [DW:0]    trial;
  logic [DW:0]    rsh;
  logic [DW:0]    lim;

  assign rsh   = {rem_r[DW-1:0], n_r[QW-1]};
  assign trial = rsh - d_r;
  assign lim   = neg_r ? (DW+1)'(1) << (DW-1) : ((DW+1)'(1) << (DW-1)) - (DW+1)'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        n_r    <= {(num[DW-1] ? DW'(-num) : DW'(num)), {FracBits{1'b0}}};
        d_r    <= {1'b0, (den[DW-1] ? DW'(-den) : DW'(den))};
        neg_r  <= num[DW-1] ^ den[DW-1];
        rem_r  <= '0;
        q_r    <= '0;
      end else if (busy_r) begin
        n_r <= n_r << 1;
        if (!trial[DW]) begin
          rem_r <= trial;
          q_r   <= {q_r[QW-2:0], 1'b1};
        end else begin
          rem_r <= rsh;
          q_r   <= {q_r[QW-2:0], 1'b0};
        end
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == (DivCntW+1)'(CntMax-1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  logic [DW:0] qsat;
  always_comb begin
    if (q_r[QW-1:DW] != '0 || {1'b0, q_r[DW-1:0]} > lim) qsat = lim;
    else qsat = {1'b0, q_r[DW-1:0]};
  end
  assign done = done_r;
  assign quo  = neg_r ? DW'(-qsat) : DW'(qsat);
endmodule

>>> src/ncrs_dp.sv
// Datapath: polynomial evaluation, start test, Newton update, divider for the Newton quotient.
module ncrs_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ncrs_pkg::ncrs_cmd_t            cmd,
  input  logic signed [ncrs_pkg::DW-1:0] start_value,
  input  logic [ncrs_pkg::TolWidth-1:0]  tol,
  output ncrs_pkg::ncrs_sts_t            sts,
  output logic signed [ncrs_pkg::DW-1:0] x_out
);
  import ncrs_pkg::*;
  localparam logic signed [DW+3:0] MaxV = (DW+4)'((64'd1 << (DW-1)) - 64'd1);
  localparam logic signed [DW+3:0] MinV = -MaxV - (DW+4)'(1);
  localparam logic signed [DW+3:0] OneV = (DW+4)'(64'd1 << FracBits);

  function automatic logic signed [DW-1:0] sat(input logic signed [DW+3:0] v);
    if (v > MaxV) return DW'(MaxV);
    else if (v < MinV) return DW'(MinV);
    else return DW'(v);
  endfunction

  function automatic logic signed [DW-1:0] fmul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    logic [DW-1:0] ma, mb;
    logic [2*DW-1:0] p;
    logic [2*DW-1:0] q;
    logic [DW-1:0] lm;
    logic neg;
    neg = a[DW-1] ^ b[DW-1];
    ma  = a[DW-1] ? DW'(-a) : DW'(a);
    mb  = b[DW-1] ? DW'(-b) : DW'(b);
    p   = ma * mb;
    q   = p >> FracBits;
    lm  = neg ? DW'(1) << (DW-1) : (DW'(1) << (DW-1)) - DW'(1);
    if (q > (2*DW)'(lm)) q = (2*DW)'(lm);
    return neg ? DW'(-q[DW-1:0]) : q[DW-1:0];
  endfunction

  logic signed [DW-1:0] x_r, sq_r, cube_r, f_r, d_r, dd_r;
  logic signed [DW-1:0] q, xn;
  logic [2*DW-1:0] p1_r, p2_r;
  logic [DW-1:0] mf, mdd, md;
  logic [DW:0] diff, dabs;
  logic small_r, div_go, div_done;
  logic signed [DW+3:0] xn_w;

  assign mf  = f_r[DW-1]  ? DW'(-f_r)  : DW'(f_r);
  assign mdd = dd_r[DW-1] ? DW'(-dd_r) : DW'(dd_r);
  assign md  = d_r[DW-1]  ? DW'(-d_r)  : DW'(d_r);
  assign div_go = (cmd.op == OP_DIVGO);
  assign xn_w = (DW+4)'(x_r) - (DW+4)'(q);
  assign xn   = sat(xn_w);
  assign diff = (DW+1)'(xn) - (DW+1)'(x_r);
  assign dabs = diff[DW] ? -diff : diff;

  ncrs_div u_div (.clk(clk), .rst_n(rst_n), .start(div_go), .num(f_r), .den(d_r),
    .done(div_done), .quo(q));

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: x_r <= start_value;
      OP_SQ:   sq_r <= fmul(x_r, x_r);
      OP_CUBE: begin
        cube_r <= fmul(sq_r, x_r);
        d_r    <= sat(3 * (DW+4)'(sq_r) - 3 * OneV);
        dd_r   <= sat(6 * (DW+4)'(x_r));
      end
      OP_FUNC: f_r <= sat((DW+4)'(cube_r) - 3 * (DW+4)'(x_r) + OneV);
      OP_TEST: begin
        p1_r <= mf * mdd;
        p2_r <= md * md;
      end
      OP_UPD: begin
        small_r <= dabs < (DW+1)'(tol);
        x_r <= xn;
      end
      default: ;
    endcase
  end

  assign sts.conv_ok    = p1_r < p2_r;
  assign sts.d_zero     = (d_r == '0);
  assign sts.div_done   = div_done;
  assign sts.step_small = small_r;
  assign x_out = x_r;
endmodule

>>> src/ncrs_ctrl.sv
// Controller: sequences evaluation, start test, Newton steps and the result handshake.
module ncrs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          out_ready,
  input  logic [ncrs_pkg::LimWidth-1:0] lim,
  input  ncrs_pkg::ncrs_sts_t           sts,
  output ncrs_pkg::ncrs_cmd_t           cmd,
  output logic                          idle,
  output logic                          out_valid,
  output logic [ncrs_pkg::LimWidth-1:0] steps,
  output logic [1:0]                    status
);
  import ncrs_pkg::*;
  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_CUBE = 4'd2, S_FUNC = 4'd3,
    S_TEST = 4'd4, S_CHK = 4'd5, S_LIM = 4'd6, S_DIV = 4'd7, S_WAIT = 4'd8,
    S_UPD = 4'd9, S_EVAL = 4'd10, S_OUT = 4'd11;
  logic [3:0] st_r, st_nxt;
  logic first_r, first_nxt;
  logic [LimWidth-1:0] steps_r, steps_nxt;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    st_nxt = st_r; first_nxt = first_r; steps_nxt = steps_r; status_nxt = status_r;
    cmd.op = OP_IDLE;
    case (st_r)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD; st_nxt = S_SQ; first_nxt = 1'b1; steps_nxt = '0;
      end
      S_SQ:   begin cmd.op = OP_SQ;   st_nxt = S_CUBE; end
      S_CUBE: begin cmd.op = OP_CUBE; st_nxt = S_FUNC; end
      S_FUNC: begin cmd.op = OP_FUNC; st_nxt = first_r ? S_TEST : S_LIM; end
      S_TEST: begin cmd.op = OP_TEST; st_nxt = S_CHK; end
      S_CHK: begin
        first_nxt = 1'b0;
        if (!sts.conv_ok) begin status_nxt = ST_NOT_CONV; st_nxt = S_OUT; end
        else st_nxt = S_LIM;
      end
      S_LIM: begin
        if (steps_r >= lim) begin status_nxt = ST_LIMIT; st_nxt = S_OUT; end
        else if (sts.d_zero) begin status_nxt = ST_ZERO_DER; st_nxt = S_OUT; end
        else st_nxt = S_DIV;
      end
      S_DIV:  begin cmd.op = OP_DIVGO; st_nxt = S_WAIT; end
      S_WAIT: if (sts.div_done) st_nxt = S_UPD;
      S_UPD:  begin cmd.op = OP_UPD; steps_nxt = steps_r + 1'b1; st_nxt = S_EVAL; end
      S_EVAL: begin
        if (sts.step_small) begin status_nxt = ST_CONVERGED; st_nxt = S_OUT; end
        else st_nxt = S_SQ;
      end
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; first_r <= 1'b0; steps_r <= '0; status_r <= ST_CONVERGED;
    end else begin
      st_r <= st_nxt; first_r <= first_nxt; steps_r <= steps_nxt; status_r <= status_nxt;
    end
  end

  assign idle = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign steps = steps_r;
  assign status = status_r;
endmodule

>>> src/newton_cubic_root_solver.sv
// Top level of the Newton root solver for x^3 - 3x + 1.
// Usage:
//   in  channel: one request carries start_value (signed Q8.24).
//   out channel: one request per input: root_value, steps_taken, status
//     (0 converged, 1 start test failed, 2 zero derivative, 3 step limit).
//   cfg channel: index 0 tolerance (Q8.24 LSBs), index 1 iteration_limit;
//     always ready, write only while idle.
// One item at a time. After the accepting edge the block runs the start
// evaluation and test, then each Newton step runs a limit check, a
// divider launch, a wait on the 56-iteration restoring divider and its
// done flag, the update, the compare and the square, cube and function states to re-evaluate f and f'.
// The divider dominates each Newton step.
// in_ready is high only while the controller is idle.
// The result is held in registers until out_ready; a stalled receiver
// stalls the block, and no new request is taken meanwhile.
// Reset (synchronous, rst_n low) returns the controller to idle and loads
// tolerance 168 and iteration_limit 99.
module newton_cubic_root_solver (
  input  logic clk,
  input  logic rst_n,
  ncrs_if.sink   in_ch,
  ncrs_if.source out_ch,
  ncrs_if.sink   cfg_ch
);
  import ncrs_pkg::*;
  logic [TolWidth-1:0] tol_r;
  logic [LimWidth-1:0] lim_r;
  ncrs_cmd_t cmd;
  ncrs_sts_t sts;
  logic idle, in_fire;
  logic signed [DW-1:0] x;
  logic [LimWidth-1:0] steps;
  logic [1:0] status;

  // cfg data: bit TolWidth (25) holds the index, the bits below it the value
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TolWidth'(168);
      lim_r <= LimWidth'(99);
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data[TolWidth] == REG_TOLERANCE) tol_r <= cfg_ch.data[TolWidth-1:0];
      else if (cfg_ch.data[TolWidth] == REG_ITER_LIM) lim_r <= cfg_ch.data[LimWidth-1:0];
    end
  end

  assign in_ch.ready = idle;
  assign in_fire = in_ch.valid && idle;

  ncrs_ctrl u_ctrl (.clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_ready(out_ch.ready),
    .lim(lim_r), .sts(sts), .cmd(cmd), .idle(idle), .out_valid(out_ch.valid),
    .steps(steps), .status(status));

  ncrs_dp u_dp (.clk(clk), .rst_n(rst_n), .cmd(cmd), .start_value(in_ch.data[DW-1:0]),
    .tol(tol_r), .sts(sts), .x_out(x));

  assign out_ch.data = {status, steps, x};

`ifndef SYNTH
  a_idle_no_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
    else $error("result changed under stall");
  a_steps_lim: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> steps <= lim_r) else $error("steps beyond limit");
`endif
endmodule
